// ===== sv/bor_pkg.sv =====
// Shared types and constants for the box overlap ratio block.
// No dependencies; every other file of the block imports this package.
package bor_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_IOU     = 2'd0;
    localparam mode_t MODE_FIRST   = 2'd1;
    localparam mode_t MODE_SMALLER = 2'd2;

endpackage

// ===== sv/bor_geom.sv =====
// Geometry front end: span overlaps in the first stage, the three areas in the second.
// Depends on bor_pkg.
module bor_geom #(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  bor_pkg::mode_t            in_mode,
    input  logic [COORD_BITS-1:0]     a_x,
    input  logic [COORD_BITS-1:0]     a_y,
    input  logic [COORD_BITS-1:0]     a_width,
    input  logic [COORD_BITS-1:0]     a_height,
    input  logic [COORD_BITS-1:0]     b_x,
    input  logic [COORD_BITS-1:0]     b_y,
    input  logic [COORD_BITS-1:0]     b_width,
    input  logic [COORD_BITS-1:0]     b_height,
    output logic                      out_valid,
    output bor_pkg::mode_t            out_mode,
    output logic [2*COORD_BITS-1:0]   inter,
    output logic [2*COORD_BITS-1:0]   area_a,
    output logic [2*COORD_BITS-1:0]   area_b
);
    import bor_pkg::*;

    localparam int AW = 2 * COORD_BITS;

    logic                  s1_valid_reg;
    mode_t                 s1_mode_reg;
    logic [COORD_BITS-1:0] ow_reg;
    logic [COORD_BITS-1:0] oh_reg;
    logic [COORD_BITS-1:0] aw_reg;
    logic [COORD_BITS-1:0] ah_reg;
    logic [COORD_BITS-1:0] bw_reg;
    logic [COORD_BITS-1:0] bh_reg;
    logic [COORD_BITS-1:0] ow_next;
    logic [COORD_BITS-1:0] oh_next;

    logic                  s2_valid_reg;
    mode_t                 s2_mode_reg;
    logic [AW-1:0]         inter_reg;
    logic [AW-1:0]         area_a_reg;
    logic [AW-1:0]         area_b_reg;

    // Spans are taken as half-open [s, s+l), which equals the inclusive form.
    function automatic logic [COORD_BITS-1:0] span_overlap(
        input logic [COORD_BITS-1:0] s1,
        input logic [COORD_BITS-1:0] l1,
        input logic [COORD_BITS-1:0] s2,
        input logic [COORD_BITS-1:0] l2
    );
        logic [COORD_BITS:0] e1;
        logic [COORD_BITS:0] e2;
        logic [COORD_BITS:0] lo;
        logic [COORD_BITS:0] hi;
        logic [COORD_BITS:0] len;
        e1  = {1'b0, s1} + {1'b0, l1};
        e2  = {1'b0, s2} + {1'b0, l2};
        lo  = (s1 > s2) ? {1'b0, s1} : {1'b0, s2};
        hi  = (e1 < e2) ? e1 : e2;
        len = hi - lo;
        return (hi > lo) ? len[COORD_BITS-1:0] : '0;
    endfunction

    assign ow_next = span_overlap(a_x, a_width, b_x, b_width);
    assign oh_next = span_overlap(a_y, a_height, b_y, b_height);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= in_mode;
        ow_reg      <= ow_next;
        oh_reg      <= oh_next;
        aw_reg      <= a_width;
        ah_reg      <= a_height;
        bw_reg      <= b_width;
        bh_reg      <= b_height;
        s2_mode_reg <= s1_mode_reg;
        inter_reg   <= ow_reg * oh_reg;
        area_a_reg  <= aw_reg * ah_reg;
        area_b_reg  <= bw_reg * bh_reg;
    end

    assign out_valid = s2_valid_reg;
    assign out_mode  = s2_mode_reg;
    assign inter     = inter_reg;
    assign area_a    = area_a_reg;
    assign area_b    = area_b_reg;

endmodule

// ===== sv/bor_denom.sv =====
// Denominator stage: union, first or smaller area chosen by the ratio mode.
// Depends on bor_pkg.
module bor_denom #(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  bor_pkg::mode_t            in_mode,
    input  logic [2*COORD_BITS-1:0]   inter,
    input  logic [2*COORD_BITS-1:0]   area_a,
    input  logic [2*COORD_BITS-1:0]   area_b,
    output logic                      out_valid,
    output logic [2*COORD_BITS-1:0]   out_inter,
    output logic [2*COORD_BITS:0]     denom,
    output logic                      den_zero
);
    import bor_pkg::*;

    localparam int AW = 2 * COORD_BITS;
    localparam int DW = AW + 1;

    logic          valid_reg;
    logic [AW-1:0] inter_reg;
    logic [DW-1:0] denom_reg;
    logic          zero_reg;
    logic [DW-1:0] merged_area;
    logic [AW-1:0] small_area;
    logic [DW-1:0] denom_next;

    assign merged_area = {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter};
    assign small_area  = (area_a < area_b) ? area_a : area_b;

    always_comb
    begin
        case (in_mode)
            MODE_IOU:   denom_next = merged_area;
            MODE_FIRST: denom_next = {1'b0, area_a};
            default:    denom_next = {1'b0, small_area};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        inter_reg <= inter;
        denom_reg <= denom_next;
        zero_reg  <= (denom_next == '0);
    end

    assign out_valid = valid_reg;
    assign out_inter = inter_reg;
    assign denom     = denom_reg;
    assign den_zero  = zero_reg;

endmodule

// ===== sv/bor_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, integer bit first.
// Depends on bor_pkg; the numerator never exceeds the denominator.
module bor_divider #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [2*COORD_BITS-1:0]   numer,
    input  logic [2*COORD_BITS:0]     denom,
    input  logic                      den_zero,
    output logic                      out_valid,
    output logic [FRAC_BITS:0]        ratio,
    output logic [2*COORD_BITS-1:0]   overlap_area
);
    import bor_pkg::*;

    localparam int AW = 2 * COORD_BITS;
    localparam int DW = AW + 1;
    localparam int QW = FRAC_BITS + 1;

    logic [QW-1:0] valid_reg;
    logic [QW-1:0] zero_reg;
    logic [DW-1:0] rem_reg   [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [QW-1:0] quo_reg   [QW];
    logic [AW-1:0] area_reg  [QW];

    logic [DW:0]   rin       [QW];
    logic [DW:0]   diff      [QW];
    logic [QW-1:0] qbit;
    logic [DW-1:0] den_in    [QW];
    logic [DW-1:0] rem_next  [QW];
    logic [QW-1:0] quo_next  [QW];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                rin[k]    = {2'b00, numer};
                den_in[k] = denom;
                quo_next[k] = '0;
            end
            else
            begin
                rin[k]    = {rem_reg[k-1], 1'b0};
                den_in[k] = den_reg[k-1];
                quo_next[k] = {quo_reg[k-1][QW-2:0], 1'b0};
            end
            diff[k]        = rin[k] - {1'b0, den_in[k]};
            qbit[k]        = ~diff[k][DW];
            rem_next[k]    = qbit[k] ? diff[k][DW-1:0] : rin[k][DW-1:0];
            quo_next[k][0] = qbit[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= {zero_reg[QW-2:0], den_zero};
        for (int k = 0; k < QW; k++)
        begin
            rem_reg[k] <= rem_next[k];
            den_reg[k] <= den_in[k];
            quo_reg[k] <= quo_next[k];
            area_reg[k] <= (k == 0) ? numer : area_reg[(k == 0) ? 0 : k-1];
        end
    end

    assign out_valid    = valid_reg[QW-1];
    assign ratio        = zero_reg[QW-1] ? '0 : quo_reg[QW-1];
    assign overlap_area = area_reg[QW-1];

endmodule

// ===== sv/box_overlap_ratio.sv =====
// Box overlap ratio: intersection area of two boxes divided by a mode-selected area.
// The pipeline has two geometry stages, one denominator stage and FRAC_BITS + 1 divider stages.
// Throughput is one box pair per cycle; busy stays low since the receiver cannot stall.
// Reset clears the pipeline valid bits and sets mode_reg to intersection over union.
// Depends on bor_pkg, bor_geom, bor_denom and bor_divider.
module box_overlap_ratio #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [COORD_BITS-1:0]     a_x,
    input  logic [COORD_BITS-1:0]     a_y,
    input  logic [COORD_BITS-1:0]     a_width,
    input  logic [COORD_BITS-1:0]     a_height,
    input  logic [COORD_BITS-1:0]     b_x,
    input  logic [COORD_BITS-1:0]     b_y,
    input  logic [COORD_BITS-1:0]     b_width,
    input  logic [COORD_BITS-1:0]     b_height,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  bor_pkg::mode_t            cfg_data,
    output logic                      done,
    output logic [FRAC_BITS:0]        ratio,
    output logic [2*COORD_BITS-1:0]   overlap_area
);
    import bor_pkg::*;

    localparam int AW = 2 * COORD_BITS;
    localparam int DW = AW + 1;

    mode_t         mode_reg;
    logic          accept;

    logic          g_valid;
    mode_t         g_mode;
    logic [AW-1:0] g_inter;
    logic [AW-1:0] g_area_a;
    logic [AW-1:0] g_area_b;

    logic          d_valid;
    logic [AW-1:0] d_inter;
    logic [DW-1:0] d_denom;
    logic          d_zero;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IOU;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    bor_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_mode   (mode_reg),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_width   (a_width),
        .a_height  (a_height),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_width   (b_width),
        .b_height  (b_height),
        .out_valid (g_valid),
        .out_mode  (g_mode),
        .inter     (g_inter),
        .area_a    (g_area_a),
        .area_b    (g_area_b)
    );

    bor_denom #(
        .COORD_BITS (COORD_BITS)
    ) u_denom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_mode   (g_mode),
        .inter     (g_inter),
        .area_a    (g_area_a),
        .area_b    (g_area_b),
        .out_valid (d_valid),
        .out_inter (d_inter),
        .denom     (d_denom),
        .den_zero  (d_zero)
    );

    bor_divider #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (d_valid),
        .numer        (d_inter),
        .denom        (d_denom),
        .den_zero     (d_zero),
        .out_valid    (done),
        .ratio        (ratio),
        .overlap_area (overlap_area)
    );

endmodule
